// ===== rtl/sls_pkg.sv =====
// Shared types and codes for the script lexer stream.
// No dependencies; used by every module of the block.
package sls_pkg;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] CLS_IDENT  = 3'd0;
  localparam logic [2:0] CLS_NUMBER = 3'd1;
  localparam logic [2:0] CLS_STRING = 3'd2;
  localparam logic [2:0] CLS_SEP    = 3'd3;
  localparam logic [2:0] CLS_OP     = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ST_UNMATCHED = 3'd2;
  localparam logic [2:0] ST_OPEN_STR  = 3'd3;
  localparam logic [2:0] ST_UNCLOSED  = 3'd4;
  localparam logic [2:0] ST_TOO_DEEP  = 3'd5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cls;
    logic [7:0]  lexeme;
    logic [2:0]  status;
    logic [15:0] pos;
  } res_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    res_t [MAX_RESULTS-1:0]     slot;
  } bundle_t;

endpackage

// ===== rtl/sls_if.sv =====
// Valid/ready channel interfaces for script bytes and lexer results.
// No dependencies.
interface sls_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  modport source (output valid, output script_byte, input ready);
  modport sink (input valid, input script_byte, output ready);
endinterface

interface sls_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  token_class;
  logic [7:0]  lexeme_byte;
  logic [2:0]  status_code;
  logic [15:0] error_position;
  logic        last_of_run;
  modport source (output valid, output result_kind, output token_class, output lexeme_byte,
                  output status_code, output error_position, output last_of_run,
                  input ready);
  modport sink (input valid, input result_kind, input token_class, input lexeme_byte,
                input status_code, input error_position, input last_of_run,
                output ready);
endinterface

// ===== rtl/sls_front.sv =====
// Lexer front end: classifies each byte, tracks lexer state, builds a result bundle.
// Depends on sls_pkg.
module sls_front #(
  parameter int DEPTH_BITS    = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           byte_i,
  input  logic [63:0]          op_low_i,
  input  logic [63:0]          op_high_i,
  output logic                 push_o,
  output sls_pkg::bundle_t     bundle_o
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_DISCARD = 3'd4;

  logic [2:0]               mode_q, mode_d;
  logic                     ws_q, ws_d;
  logic [DEPTH_BITS-1:0]    depth_q, depth_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [15:0]              pos_rep;
  logic                     ws_eff;
  logic                     idle;
  logic [1:0]               k;
  sls_pkg::res_t [sls_pkg::MAX_RESULTS-1:0] r;
  logic                     is_alpha, is_digit, is_space, is_op;

  generate
    if (POSITION_BITS > 16) begin : g_sat
      assign pos_rep = (|pos_q[POSITION_BITS-1:16]) ? 16'hFFFF : pos_q[15:0];
    end else begin : g_ext
      assign pos_rep = 16'(pos_q);
    end
  endgenerate

  function automatic sls_pkg::res_t mk(logic [1:0] kind, logic [2:0] cls, logic [7:0] lex,
                                       logic [2:0] status, logic [15:0] pos);
    sls_pkg::res_t t;
    t.kind   = kind;
    t.cls    = cls;
    t.lexeme = lex;
    t.status = status;
    t.pos    = pos;
    return t;
  endfunction

  assign is_alpha = (byte_i >= 8'h61 && byte_i <= 8'h7A) || (byte_i >= 8'h41 && byte_i <= 8'h5A);
  assign is_digit = byte_i >= 8'h30 && byte_i <= 8'h39;
  assign is_space = byte_i == 8'h20 || (byte_i >= 8'h09 && byte_i <= 8'h0D);
  assign is_op    = !byte_i[7] && (byte_i[6] ? op_high_i[byte_i[5:0]] : op_low_i[byte_i[5:0]]);

  always_comb begin
    mode_d  = mode_q;
    ws_d    = ws_q;
    depth_d = depth_q;
    pos_d   = (pos_q != {POSITION_BITS{1'b1}}) ? POSITION_BITS'(pos_q + 1'b1) : pos_q;
    k       = 2'd0;
    r       = '0;
    idle    = 1'b0;
    ws_eff  = ws_q;
    case (mode_q)
      MODE_DISCARD: begin
        if (byte_i == sls_pkg::CH_NUL) begin
          mode_d  = MODE_IDLE;
          ws_d    = 1'b1;
          depth_d = '0;
          pos_d   = '0;
        end
      end
      MODE_STRING: begin
        if (byte_i == sls_pkg::CH_QUOTE) begin
          r[k] = mk(sls_pkg::KIND_END, sls_pkg::CLS_STRING, 8'd0, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
          mode_d = MODE_IDLE;
          ws_d   = 1'b0;
        end else if (byte_i == sls_pkg::CH_NUL) begin
          r[k] = mk(sls_pkg::KIND_END, sls_pkg::CLS_STRING, 8'd0, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
          r[k] = mk(sls_pkg::KIND_STATUS, sls_pkg::CLS_IDENT, 8'd0, sls_pkg::ST_OPEN_STR,
                    pos_rep);
          k = k + 2'd1;
          mode_d  = MODE_IDLE;
          ws_d    = 1'b1;
          depth_d = '0;
          pos_d   = '0;
        end else begin
          r[k] = mk(sls_pkg::KIND_CHAR, sls_pkg::CLS_STRING, byte_i, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
        end
      end
      MODE_IDENT: begin
        if (byte_i == sls_pkg::CH_UNDER || is_alpha || is_digit) begin
          r[k] = mk(sls_pkg::KIND_CHAR, sls_pkg::CLS_IDENT, byte_i, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
        end else begin
          r[k] = mk(sls_pkg::KIND_END, sls_pkg::CLS_IDENT, 8'd0, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
          ws_eff = 1'b0;
          idle   = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit || byte_i == sls_pkg::CH_DOT) begin
          r[k] = mk(sls_pkg::KIND_CHAR, sls_pkg::CLS_NUMBER, byte_i, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
        end else begin
          r[k] = mk(sls_pkg::KIND_END, sls_pkg::CLS_NUMBER, 8'd0, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
          ws_eff = 1'b0;
          idle   = 1'b1;
        end
      end
      default: idle = 1'b1;
    endcase

    if (idle) begin
      mode_d = MODE_IDLE;
      ws_d   = ws_eff;
      if (byte_i == sls_pkg::CH_NUL) begin
        r[k] = mk(sls_pkg::KIND_STATUS, sls_pkg::CLS_IDENT, 8'd0,
                  (depth_q != '0) ? sls_pkg::ST_UNCLOSED : sls_pkg::ST_OK, pos_rep);
        k = k + 2'd1;
        ws_d    = 1'b1;
        depth_d = '0;
        pos_d   = '0;
      end else if (ws_eff && is_alpha) begin
        mode_d = MODE_IDENT;
        r[k] = mk(sls_pkg::KIND_CHAR, sls_pkg::CLS_IDENT, byte_i, sls_pkg::ST_OK, 16'd0);
        k = k + 2'd1;
      end else if (ws_eff && is_digit) begin
        mode_d = MODE_NUMBER;
        r[k] = mk(sls_pkg::KIND_CHAR, sls_pkg::CLS_NUMBER, byte_i, sls_pkg::ST_OK, 16'd0);
        k = k + 2'd1;
      end else if (ws_eff && byte_i == sls_pkg::CH_QUOTE) begin
        mode_d = MODE_STRING;
      end else if (byte_i == sls_pkg::CH_COMMA) begin
        r[k] = mk(sls_pkg::KIND_CHAR, sls_pkg::CLS_SEP, byte_i, sls_pkg::ST_OK, 16'd0);
        k = k + 2'd1;
        r[k] = mk(sls_pkg::KIND_END, sls_pkg::CLS_SEP, 8'd0, sls_pkg::ST_OK, 16'd0);
        k = k + 2'd1;
        ws_d = 1'b1;
      end else if (byte_i == sls_pkg::CH_LPAREN) begin
        if (&depth_q) begin
          r[k] = mk(sls_pkg::KIND_STATUS, sls_pkg::CLS_IDENT, 8'd0, sls_pkg::ST_TOO_DEEP,
                    pos_rep);
          k = k + 2'd1;
          mode_d = MODE_DISCARD;
        end else begin
          depth_d = DEPTH_BITS'(depth_q + 1'b1);
          r[k] = mk(sls_pkg::KIND_CHAR, sls_pkg::CLS_OP, byte_i, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
          r[k] = mk(sls_pkg::KIND_END, sls_pkg::CLS_OP, 8'd0, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
          ws_d = 1'b1;
        end
      end else if (byte_i == sls_pkg::CH_RPAREN) begin
        if (depth_q != '0) begin
          depth_d = DEPTH_BITS'(depth_q - 1'b1);
          r[k] = mk(sls_pkg::KIND_CHAR, sls_pkg::CLS_OP, byte_i, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
          r[k] = mk(sls_pkg::KIND_END, sls_pkg::CLS_OP, 8'd0, sls_pkg::ST_OK, 16'd0);
          k = k + 2'd1;
          ws_d = 1'b1;
        end else begin
          r[k] = mk(sls_pkg::KIND_STATUS, sls_pkg::CLS_IDENT, 8'd0, sls_pkg::ST_UNMATCHED,
                    pos_rep);
          k = k + 2'd1;
          mode_d = MODE_DISCARD;
        end
      end else if (is_op) begin
        r[k] = mk(sls_pkg::KIND_CHAR, sls_pkg::CLS_OP, byte_i, sls_pkg::ST_OK, 16'd0);
        k = k + 2'd1;
        r[k] = mk(sls_pkg::KIND_END, sls_pkg::CLS_OP, 8'd0, sls_pkg::ST_OK, 16'd0);
        k = k + 2'd1;
        ws_d = 1'b1;
      end else if (is_space) begin
        ws_d = 1'b1;
      end else begin
        r[k] = mk(sls_pkg::KIND_STATUS, sls_pkg::CLS_IDENT, 8'd0, sls_pkg::ST_BAD_CHAR,
                  pos_rep);
        k = k + 2'd1;
        mode_d = MODE_DISCARD;
      end
    end
  end

  assign push_o        = accept_i && (k != 2'd0);
  assign bundle_o.cnt  = k;
  assign bundle_o.slot = r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      ws_q    <= 1'b1;
      depth_q <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      ws_q    <= ws_d;
      depth_q <= depth_d;
      pos_q   <= pos_d;
    end
  end

  a_discard_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DISCARD) |-> !push_o)
    else $error("result produced while discarding");
  a_pos_clears_on_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && byte_i == sls_pkg::CH_NUL) |=> (pos_q == '0 && depth_q == '0))
    else $error("state not rearmed after terminator");
  a_ident_word_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && mode_q == MODE_IDLE && !ws_q) |=> (mode_q != MODE_IDENT))
    else $error("token started off word start");

endmodule

// ===== rtl/sls_queue.sv =====
// Two-entry bundle queue between the lexer front end and the result sequencer.
// Depends on sls_pkg.
module sls_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sls_pkg::bundle_t  push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output sls_pkg::bundle_t  head_o
);

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);

  sls_pkg::bundle_t     mem_q [QDEPTH];
  logic [PW-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]          cnt_q, cnt_d;

  assign full_o  = cnt_q == (PW+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? PW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop_i ? PW'(rd_q + 1'b1) : rd_q;
    cnt_d = (PW+1)'(cnt_q + (push_i ? 1'b1 : 1'b0) - (pop_i ? 1'b1 : 1'b0));
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/sls_back.sv =====
// Result sequencer: walks the head bundle one result per output handshake.
// Depends on sls_pkg and sls_if.
module sls_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  sls_pkg::bundle_t   head_i,
  output logic               pop_o,
  sls_result_if.source       res_o
);

  logic [1:0]    idx_q, idx_d;
  logic          last;
  logic          fire;
  sls_pkg::res_t cur;

  assign cur  = head_i.slot[idx_q];
  assign last = idx_q == 2'(head_i.cnt - 2'd1);
  assign fire = res_o.valid && res_o.ready;

  assign res_o.valid          = valid_i;
  assign res_o.result_kind    = cur.kind;
  assign res_o.token_class    = cur.cls;
  assign res_o.lexeme_byte    = cur.lexeme;
  assign res_o.status_code    = cur.status;
  assign res_o.error_position = cur.pos;
  assign res_o.last_of_run    = last;

  assign pop_o = fire && last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last ? 2'd0 : 2'(idx_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (idx_q < head_i.cnt))
    else $error("result index beyond bundle");
  a_stall_holds_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> $stable(idx_q))
    else $error("index moved during stall");
  a_idx_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |-> (idx_q == 2'd0))
    else $error("index not cleared with empty queue");

endmodule

// ===== rtl/script_lexer_stream.sv =====
// Script lexer stream: one script byte in, zero to three results out.
// A byte's bundle is registered in the queue before its first result is offered.
// Throughput: one byte per cycle unless the queue is full; the result sequencer sends
// a byte's n results one per handshake; a two-bundle queue absorbs the difference.
// Reset: asynchronous, clears lexer state, queue and operator bitmaps; no clearing pass.
// Depends on sls_pkg, sls_if, sls_front, sls_queue and sls_back.
module script_lexer_stream #(
  parameter int DEPTH_BITS    = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sls_byte_if.sink      byte_i,
  sls_result_if.source  res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  logic [63:0]      op_low_q, op_high_q;
  logic             q_full, q_valid, push, pop, accept;
  sls_pkg::bundle_t push_data, head;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? op_high_q : op_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_low_q  <= '0;
      op_high_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        op_high_q <= pwdata;
      end else begin
        op_low_q <= pwdata;
      end
    end
  end

  assign byte_i.ready = !q_full;
  assign accept       = byte_i.valid && !q_full;

  sls_front #(
    .DEPTH_BITS    (DEPTH_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_i    (byte_i.script_byte),
    .op_low_i  (op_low_q),
    .op_high_i (op_high_q),
    .push_o    (push),
    .bundle_o  (push_data)
  );

  sls_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  sls_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (head),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
